### design/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is low
`define TCCW_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// clocked property, checked during reset too
`define TCCW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### design/tccw_pkg.sv
// types, codes and constants of the text console character writer
`default_nettype none

package tccw_pkg;

  localparam int unsigned MAX_CELLS_DEF = 4096;
  localparam int unsigned MAX_COLS_DEF  = 128;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned CUR_W      = 13;
  localparam int unsigned ROW_W      = 6;
  localparam int unsigned COL_CNT_W  = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [ROW_W-1:0]     ROW_COUNT_RST    = 6'd27;
  localparam logic [COL_CNT_W-1:0] COLUMN_COUNT_RST = 8'd80;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd1;

  localparam logic [CH_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CH_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CH_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CH_W-1:0] CH_SPACE     = 8'h20;

  localparam int unsigned TAB_STOP = 4;
  localparam int unsigned TAB_BITS = $clog2(TAB_STOP);

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [CH_W-1:0]  ch;
    logic [IDX_W-1:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]  read_char;
    logic [CUR_W-1:0] cursor;
    logic             scrolled;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_GEOM,
    ST_SCROLL,
    ST_EXEC,
    ST_READ,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    G_IDLE,
    G_ROWS,
    G_MOD
  } geom_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } geom_stat_t;

endpackage

`default_nettype wire

### design/tccw_geom.sv
// grid geometry unit: clamped columns, total cells and cursor column
`default_nettype none

module tccw_geom import tccw_pkg::*; #(
  parameter int unsigned MAX_CELLS = MAX_CELLS_DEF,
  parameter int unsigned MAX_COLS  = MAX_COLS_DEF,
  localparam int unsigned TW = $clog2(MAX_CELLS + 1),
  localparam int unsigned CW = $clog2(MAX_COLS + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [ROW_W-1:0]     row_count_i,
  input  logic [COL_CNT_W-1:0] column_count_i,
  input  logic [TW-1:0]        cursor_i,
  output geom_stat_t           stat_o,
  output logic [CW-1:0]        cols_o,
  output logic [TW-1:0]        total_o,
  output logic [CW-1:0]        col_o
);

  localparam int unsigned CLIM = (MAX_COLS < MAX_CELLS) ? MAX_COLS : MAX_CELLS;
  localparam int unsigned PW   = ROW_W + CW;
  localparam int unsigned NW   = $clog2(TW + 1);

  geom_state_e          state_q, state_d;
  logic [ROW_W-1:0]     rows_q, rows_d;
  logic [CW-1:0]        cols_q, cols_d;
  logic [TW-1:0]        total_q, total_d;
  logic [TW-1:0]        sh_q, sh_d;
  logic [CW-1:0]        rem_q, rem_d;
  logic [NW-1:0]        cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic [COL_CNT_W-1:0] cc_nz;
  logic [CW-1:0]        cols_eff;
  logic [PW-1:0]        prod;
  logic                 prod_fits;
  logic [CW:0]          rem_ext;
  logic                 last_step;

  always_comb begin
    cc_nz = (column_count_i == '0) ? COL_CNT_W'(1) : column_count_i;
    if (32'(cc_nz) > CLIM) begin
      cols_eff = CW'(CLIM);
    end else begin
      cols_eff = CW'(cc_nz);
    end
  end

  assign prod      = PW'(rows_q) * PW'(cols_q);
  assign prod_fits = (32'(prod) <= 32'(MAX_CELLS));
  assign rem_ext   = {rem_q, sh_q[TW-1]};
  assign last_step = (cnt_q == NW'(TW - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      G_IDLE: if (start_i) state_d = G_ROWS;
      G_ROWS: if (prod_fits) state_d = G_MOD;
      G_MOD:  if (last_step) state_d = G_IDLE;
      default: state_d = G_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    rows_d  = rows_q;
    cols_d  = cols_q;
    total_d = total_q;
    sh_d    = sh_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    unique case (state_q)
      G_IDLE: begin
        if (start_i) begin
          cols_d = cols_eff;
          rows_d = (row_count_i == '0) ? ROW_W'(1) : row_count_i;
          sh_d   = cursor_i;
          rem_d  = '0;
          cnt_d  = '0;
        end
      end
      G_ROWS: begin
        // shrink the row count until the grid fits the store
        if (prod_fits) begin
          total_d = TW'(prod);
        end else begin
          rows_d = rows_q - ROW_W'(1);
        end
      end
      G_MOD: begin
        // restoring remainder of the cursor, one bit per cycle
        if (rem_ext >= {1'b0, cols_q}) begin
          rem_d = CW'(rem_ext - {1'b0, cols_q});
        end else begin
          rem_d = CW'(rem_ext);
        end
        sh_d   = sh_q << 1;
        cnt_d  = cnt_q + NW'(1);
        done_d = last_step;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= G_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rows_q  <= rows_d;
    cols_q  <= cols_d;
    total_q <= total_d;
    sh_q    <= sh_d;
    rem_q   <= rem_d;
    cnt_q   <= cnt_d;
  end

  assign stat_o.busy = (state_q != G_IDLE);
  assign stat_o.done = done_q;
  assign cols_o      = cols_q;
  assign total_o     = total_q;
  assign col_o       = rem_q;

endmodule

`default_nettype wire

### design/text_console_char_writer_unit.sv
// top level of the text console character writer
`default_nettype none
`include "assert_macros.svh"

// channel | dir | handshake                 | beat
// in      | in  | in_valid_i / in_ready_o   | in_item_t: cmd, ch, cell_index
// out     | out | out_valid_o / out_ready_i | out_item_t: read_char, cursor, scrolled
// cfg     | in  | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i (always ready)
//
// write or read: exec or read state, then out loads the result; unused goes to out
// a write that scrolls first runs a copy sweep that moves one cell per cycle
//   through the single write port of the cell store
// clear runs a fill sweep over all MAX_CELLS cells; reset runs the same sweep first
// after a config write the geometry unit runs a row clamp loop, one multiply per
//   cycle, then a bit-serial cursor column
// a finished result waits in the output register while the next beat is accepted

module text_console_char_writer_unit import tccw_pkg::*; #(
  parameter int unsigned MAX_CELLS = MAX_CELLS_DEF,
  parameter int unsigned MAX_COLS  = MAX_COLS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned AW  = $clog2(MAX_CELLS);
  localparam int unsigned TW  = $clog2(MAX_CELLS + 1);
  localparam int unsigned CW  = $clog2(MAX_COLS + 1);
  localparam int unsigned TSW = TAB_BITS + 1;

  // cell store, one write and one registered read per cycle
  logic [CH_W-1:0] cell_mem_q [MAX_CELLS];
  logic [CH_W-1:0] rdata_q;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [CH_W-1:0] mem_wdata;
  logic [AW-1:0]   mem_raddr;

  state_e               state_q, state_d;
  logic                 dirty_q, dirty_d;
  logic                 clr_pend_q, clr_pend_d;
  logic [TW-1:0]        cnt_q, cnt_d;
  logic [TW-1:0]        cur_q, cur_d;
  logic [CW-1:0]        col_q, col_d;
  logic [CH_W-1:0]      ch_q, ch_d;
  logic                 in_range_q, in_range_d;
  logic [CH_W-1:0]      res_char_q, res_char_d;
  logic                 scr_q, scr_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q, out_d;
  logic [ROW_W-1:0]     row_count_q, row_count_d;
  logic [COL_CNT_W-1:0] column_count_q, column_count_d;

  logic          in_acc;
  logic          out_free;
  logic          cfg_wr;
  logic          geom_start;
  geom_stat_t    geom_stat;
  logic [CW-1:0] g_cols;
  logic [TW-1:0] g_total;
  logic [CW-1:0] g_col;
  logic [TW-1:0] cols_t;
  logic [TW-1:0] keep;
  logic [TSW-1:0] tab_step;
  logic [TW:0]   tab_sum;
  logic [CW:0]   tab_col;

  tccw_geom #(
    .MAX_CELLS(MAX_CELLS),
    .MAX_COLS (MAX_COLS)
  ) u_geom (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (geom_start),
    .row_count_i   (row_count_q),
    .column_count_i(column_count_q),
    .cursor_i      (cur_q),
    .stat_o        (geom_stat),
    .cols_o        (g_cols),
    .total_o       (g_total),
    .col_o         (g_col)
  );

  assign in_ready_o  = (state_q == ST_IDLE) && !dirty_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  // cells kept when the grid scrolls up one row
  assign cols_t = TW'(g_cols);
  assign keep   = g_total - cols_t;

  // tab: step to the next stop, column wraps at most once per unit of step
  always_comb begin
    tab_step = TSW'(TAB_STOP) - {1'b0, cur_q[TAB_BITS-1:0]};
    tab_sum  = {1'b0, cur_q} + (TW + 1)'(tab_step);
    tab_col  = {1'b0, col_q} + (CW + 1)'(tab_step);
    for (int k = 0; k < TAB_STOP; k++) begin
      if (tab_col >= {1'b0, g_cols}) tab_col = tab_col - {1'b0, g_cols};
    end
  end

  // config registers; any write forces a geometry update
  always_comb begin
    row_count_d    = row_count_q;
    column_count_d = column_count_q;
    if (cfg_wr) begin
      unique case (cfg_index_i)
        CFG_ROW_COUNT:    row_count_d    = cfg_data_i[ROW_W-1:0];
        CFG_COLUMN_COUNT: column_count_d = cfg_data_i[COL_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_FILL: begin
        if (cnt_q == TW'(MAX_CELLS - 1)) state_d = clr_pend_q ? ST_OUT : ST_IDLE;
      end
      ST_IDLE: begin
        if (dirty_q) begin
          state_d = ST_GEOM;
        end else if (in_acc) begin
          unique case (cmd_e'(in_data_i.cmd))
            CMD_WRITE: state_d = (cur_q >= g_total) ? ST_SCROLL : ST_EXEC;
            CMD_CLEAR: state_d = ST_FILL;
            CMD_READ:  state_d = ST_READ;
            default:   state_d = ST_OUT;
          endcase
        end
      end
      ST_GEOM:   if (geom_stat.done) state_d = ST_IDLE;
      ST_SCROLL: if (cnt_q == g_total) state_d = ST_EXEC;
      ST_EXEC:   state_d = ST_OUT;
      ST_READ:   state_d = ST_OUT;
      ST_OUT:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath and store controls
  always_comb begin
    dirty_d     = dirty_q;
    clr_pend_d  = clr_pend_q;
    cnt_d       = cnt_q;
    cur_d       = cur_q;
    col_d       = col_q;
    ch_d        = ch_q;
    in_range_d  = in_range_q;
    res_char_d  = res_char_q;
    scr_d       = scr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    geom_start  = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = AW'(cnt_q);
    mem_wdata   = CH_SPACE;
    mem_raddr   = AW'(in_data_i.cell_index);

    unique case (state_q)
      ST_FILL: begin
        mem_we = 1'b1;
        cnt_d  = cnt_q + TW'(1);
        if (cnt_q == TW'(MAX_CELLS - 1)) clr_pend_d = 1'b0;
      end
      ST_IDLE: begin
        if (dirty_q) begin
          geom_start = 1'b1;
          dirty_d    = 1'b0;
        end else if (in_acc) begin
          ch_d       = in_data_i.ch;
          res_char_d = '0;
          scr_d      = 1'b0;
          cnt_d      = '0;
          in_range_d = (32'(in_data_i.cell_index) < 32'(g_total));
          unique case (cmd_e'(in_data_i.cmd))
            CMD_WRITE: scr_d = (cur_q >= g_total);
            CMD_CLEAR: begin
              cur_d      = '0;
              col_d      = '0;
              clr_pend_d = 1'b1;
            end
            CMD_READ: ;
            default: ;
          endcase
        end
      end
      ST_GEOM: begin
        if (geom_stat.done) col_d = g_col;
      end
      ST_SCROLL: begin
        // read one row ahead, write the cell behind it; bottom row gets spaces
        mem_raddr = AW'(cnt_q + cols_t);
        if (cnt_q != '0) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(cnt_q - TW'(1));
          mem_wdata = (cnt_q <= keep) ? rdata_q : CH_SPACE;
        end
        cnt_d = cnt_q + TW'(1);
        if (cnt_q == g_total) begin
          cur_d = keep;
          col_d = '0;
        end
      end
      ST_EXEC: begin
        case (ch_q)
          CH_NEWLINE: begin
            cur_d = cur_q - TW'(col_q) + cols_t;
            col_d = '0;
          end
          CH_TAB: begin
            if (tab_sum >= {1'b0, g_total}) begin
              cur_d = g_total;
              col_d = '0;
            end else begin
              cur_d = tab_sum[TW-1:0];
              col_d = tab_col[CW-1:0];
            end
          end
          CH_BACKSPACE: begin
            // at home position nothing happens
            if (cur_q != '0) begin
              mem_we    = 1'b1;
              mem_waddr = AW'(cur_q - TW'(1));
              mem_wdata = CH_SPACE;
              cur_d     = cur_q - TW'(1);
              col_d     = (col_q == '0) ? g_cols - CW'(1) : col_q - CW'(1);
            end
          end
          default: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(cur_q);
            mem_wdata = ch_q;
            cur_d     = cur_q + TW'(1);
            col_d     = (col_q + CW'(1) == g_cols) ? '0 : col_q + CW'(1);
          end
        endcase
      end
      ST_READ: begin
        res_char_d = in_range_q ? rdata_q : CH_SPACE;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d.read_char = res_char_q;
          out_d.cursor    = CUR_W'(cur_q);
          out_d.scrolled  = scr_q;
        end
      end
      default: ;
    endcase

    if (cfg_wr) dirty_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_FILL;
      dirty_q        <= 1'b1;
      clr_pend_q     <= 1'b0;
      cnt_q          <= '0;
      cur_q          <= '0;
      col_q          <= '0;
      out_valid_q    <= 1'b0;
      row_count_q    <= ROW_COUNT_RST;
      column_count_q <= COLUMN_COUNT_RST;
    end else begin
      state_q        <= state_d;
      dirty_q        <= dirty_d;
      clr_pend_q     <= clr_pend_d;
      cnt_q          <= cnt_d;
      cur_q          <= cur_d;
      col_q          <= col_d;
      out_valid_q    <= out_valid_d;
      row_count_q    <= row_count_d;
      column_count_q <= column_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q       <= ch_d;
    in_range_q <= in_range_d;
    res_char_q <= res_char_d;
    scr_q      <= scr_d;
    out_q      <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) cell_mem_q[mem_waddr] <= mem_wdata;
    rdata_q <= cell_mem_q[mem_raddr];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `TCCW_ASSERT(a_accept_leaves_idle, clk_i, rst_ni, in_valid_i && in_ready_o |=> state_q != ST_IDLE, "accepted beat did not start work")
  `TCCW_ASSERT(a_col_in_row, clk_i, rst_ni, (state_q == ST_IDLE && !dirty_q) |-> (col_q < g_cols), "cursor column outside row")
  `TCCW_ASSERT(a_scroll_in_grid, clk_i, rst_ni, (state_q == ST_SCROLL && mem_we) |-> (mem_waddr < g_total), "scroll write outside grid")
  `TCCW_ASSERT(a_ready_geom_idle, clk_i, rst_ni, in_ready_o |-> !geom_stat.busy, "ready while geometry busy")

endmodule

`default_nettype wire

### bench/tccw_checker.sv
`timescale 1ns / 1ps
// scoreboard for the text console writer: shadow grid, cursor and beat compare
module tccw_checker import tccw_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  in_item_t              in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  out_item_t             out_data_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    mismatch_count_o,
  output int                    outstanding_o
);

  logic [CH_W-1:0]      grid_cells [0:MAX_CELLS_DEF-1];
  logic [CUR_W-1:0]     grid_cursor;
  logic [ROW_W-1:0]     rows_reg;
  logic [COL_CNT_W-1:0] cols_reg;
  out_item_t            predicted_beats [$];

  // applies one command to the shadow grid and returns the beat it should produce
  function automatic out_item_t console_step(input in_item_t beat);
    int unsigned cols;
    int unsigned rows;
    int unsigned total;
    int unsigned cur;
    int unsigned keep;
    out_item_t   res;
    cols = (cols_reg == 0) ? 1 : cols_reg;
    if (cols > MAX_COLS_DEF) cols = MAX_COLS_DEF;
    if (cols > MAX_CELLS_DEF) cols = MAX_CELLS_DEF;
    rows = (rows_reg == 0) ? 1 : rows_reg;
    if (rows > MAX_CELLS_DEF / cols) rows = MAX_CELLS_DEF / cols;
    total = rows * cols;
    res = '0;
    case (beat.cmd)
      CMD_WRITE: begin
        cur = grid_cursor;
        if (cur >= total) begin
          // scroll up one row, blank bottom row, cursor to its start
          keep = total - cols;
          for (int i = 0; i < keep; i++) grid_cells[i] = grid_cells[i + cols];
          for (int i = keep; i < total; i++) grid_cells[i] = CH_SPACE;
          cur = keep;
          res.scrolled = 1'b1;
        end
        if (beat.ch == CH_NEWLINE) begin
          cur = cur + cols - (cur % cols);
        end else if (beat.ch == CH_TAB) begin
          cur = cur + TAB_STOP - (cur % TAB_STOP);
          if (cur > total) cur = total;
        end else if (beat.ch == CH_BACKSPACE) begin
          if (cur > 0) begin
            cur--;
            grid_cells[cur] = CH_SPACE;
          end
        end else begin
          grid_cells[cur] = beat.ch;
          cur++;
        end
        grid_cursor = cur[CUR_W-1:0];
      end
      CMD_CLEAR: begin
        foreach (grid_cells[i]) grid_cells[i] = CH_SPACE;
        grid_cursor = '0;
      end
      CMD_READ: begin
        res.read_char = (beat.cell_index < total) ? grid_cells[beat.cell_index] : CH_SPACE;
      end
      default: ;
    endcase
    res.cursor = grid_cursor;
    return res;
  endfunction

  task automatic flag_field(input string field, input int unsigned want,
                            input int unsigned got);
    if (want != got) begin
      if (mismatch_count_o < 40)
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
      mismatch_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      foreach (grid_cells[i]) grid_cells[i] = CH_SPACE;
      grid_cursor = '0;
      rows_reg = ROW_COUNT_RST;
      cols_reg = COLUMN_COUNT_RST;
      predicted_beats.delete();
      mismatch_count_o = 0;
      outstanding_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_ROW_COUNT:    rows_reg = cfg_data_i[ROW_W-1:0];
          CFG_COLUMN_COUNT: cols_reg = cfg_data_i;
          default: ;
        endcase
      end
      // results leave before the new beat is modeled, never the other way round
      if (out_valid_i && out_ready_i) begin
        if (predicted_beats.size() == 0) begin
          if (mismatch_count_o < 40)
            $display("%0t: unexpected result beat, expected none actual %0h",
                     $time, out_data_i);
          mismatch_count_o++;
        end else begin
          want = predicted_beats.pop_front();
          flag_field("read_char", want.read_char, out_data_i.read_char);
          flag_field("cursor", want.cursor, out_data_i.cursor);
          flag_field("scrolled", want.scrolled, out_data_i.scrolled);
        end
      end
      if (in_valid_i && in_ready_i) predicted_beats.push_back(console_step(in_data_i));
      outstanding_o = predicted_beats.size();
    end
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// stimulus and verdict for the text console character writer
module testbench;
  import tccw_pkg::*;

  // codes the package leaves unnamed: the spare command and register slots
  localparam logic [CMD_W-1:0]     CMD_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  // worst case is a full-grid scroll or clear sweep per beat
  localparam int unsigned CYCLE_LIMIT     = 20_000_000;
  localparam int unsigned RANDOM_PHASES   = 16;
  localparam int unsigned BEATS_PER_PHASE = 64;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    mismatches;
  int                    outstanding;
  int unsigned           cycle_count = 0;

  // geometry as last written, only used to aim read indexes into the grid
  int unsigned           cur_rows = 27;
  int unsigned           cur_cols = 80;
  // shared pacing knobs: no_idle turns off random gaps on both sides,
  // rx_hold_cycles asks the receiver for one long stall
  bit                    no_idle = 1'b0;
  int unsigned           rx_hold_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_console_char_writer_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  tccw_checker checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .out_data_i      (out_data),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .mismatch_count_o(mismatches),
    .outstanding_o   (outstanding)
  );

  // watchdog: a hang anywhere ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic in_item_t beat_of(input logic [CMD_W-1:0] cmd,
                                       input logic [CH_W-1:0] ch,
                                       input logic [IDX_W-1:0] idx);
    in_item_t b;
    b.cmd = cmd;
    b.ch = ch;
    b.cell_index = idx;
    return b;
  endfunction

  // mostly writes with control bytes boosted, a fair share of reads,
  // rare clears (each costs a full fill sweep) and the odd spare command
  function automatic in_item_t random_beat();
    in_item_t    b;
    int unsigned sel;
    int unsigned span;
    b.cmd = CMD_WRITE;
    b.ch = $urandom_range(0, 255);
    b.cell_index = $urandom_range(0, 4095);
    sel = $urandom_range(0, 99);
    if (sel < 2) begin
      b.cmd = CMD_CLEAR;
    end else if (sel < 4) begin
      b.cmd = CMD_UNUSED;
    end else if (sel < 26) begin
      b.cmd = CMD_READ;
      // three reads in four land in or just past the grid
      if ($urandom_range(0, 3) != 0) begin
        span = ((cur_rows % 64) + 1) * (cur_cols + 1);
        if (span > 4095) span = 4095;
        b.cell_index = $urandom_range(0, span);
      end
    end else begin
      sel = $urandom_range(0, 99);
      if (sel < 8) b.ch = CH_NEWLINE;
      else if (sel < 14) b.ch = CH_TAB;
      else if (sel < 20) b.ch = CH_BACKSPACE;
    end
    return b;
  endfunction

  // offer one beat after a random gap; valid stays high on return so a
  // back-to-back beat never lowers and raises it in the same step
  task automatic send_beat(input in_item_t beat);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and hold off until every predicted result has come back;
  // the count is looked at on the falling edge, clear of the checker's update
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // new geometry only while idle; the spare slots get a poke now and then
  task automatic set_geometry(input logic [CFG_DATA_W-1:0] rows,
                              input logic [CFG_DATA_W-1:0] cols,
                              input bit poke_spares);
    drain();
    write_reg(CFG_ROW_COUNT, rows);
    write_reg(CFG_COLUMN_COUNT, cols);
    if (poke_spares) begin
      write_reg(CFG_SPARE_A, $urandom_range(0, 255));
      write_reg(CFG_SPARE_B, $urandom_range(0, 255));
    end
    cfg_valid <= 1'b0;
    cur_rows = rows;
    cur_cols = cols;
  endtask

  // receiver: random stall per result, plus one long hold when asked
  initial begin
    int unsigned hold;
    int unsigned stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (rx_hold_cycles != 0) begin
        hold = rx_hold_cycles;
        rx_hold_cycles = 0;
        repeat (hold) begin
          out_ready <= 1'b0;
          @(posedge clk);
        end
      end
      stall = no_idle ? 0 : $urandom_range(0, 7);
      repeat (stall) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] rows;
    logic [CFG_DATA_W-1:0] cols;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset geometry 27x80: fresh cells, the outermost index, the last cell
    send_beat(beat_of(CMD_READ, 8'h00, 12'd0));
    send_beat(beat_of(CMD_READ, 8'hFF, 12'hFFF));
    send_beat(beat_of(CMD_READ, 8'h00, 12'd2159));
    // extreme bytes, then each control byte
    send_beat(beat_of(CMD_WRITE, 8'h41, 12'hFFF));
    send_beat(beat_of(CMD_WRITE, 8'hFF, 12'd0));
    send_beat(beat_of(CMD_WRITE, 8'h00, 12'd0));
    send_beat(beat_of(CMD_WRITE, CH_TAB, 12'd0));
    send_beat(beat_of(CMD_WRITE, CH_NEWLINE, 12'd0));
    send_beat(beat_of(CMD_WRITE, CH_BACKSPACE, 12'd0));
    send_beat(beat_of(CMD_READ, 8'h00, 12'd2));
    // clear homes the cursor, so backspace at the origin must do nothing
    send_beat(beat_of(CMD_CLEAR, 8'hFF, 12'hFFF));
    send_beat(beat_of(CMD_WRITE, CH_BACKSPACE, 12'd0));
    send_beat(beat_of(CMD_UNUSED, 8'hFF, 12'hFFF));

    // 2x3 grid: tab clamped at the end, write at the end scrolls, newline to end
    set_geometry(8'd2, 8'd3, 1'b0);
    send_beat(beat_of(CMD_WRITE, 8'h78, 12'd0));
    send_beat(beat_of(CMD_WRITE, 8'h79, 12'd0));
    send_beat(beat_of(CMD_WRITE, CH_TAB, 12'd0));
    send_beat(beat_of(CMD_WRITE, 8'h7A, 12'd0));
    send_beat(beat_of(CMD_WRITE, CH_TAB, 12'd0));
    send_beat(beat_of(CMD_WRITE, 8'h77, 12'd0));
    send_beat(beat_of(CMD_WRITE, CH_NEWLINE, 12'd0));
    send_beat(beat_of(CMD_READ, 8'h00, 12'd0));
    send_beat(beat_of(CMD_READ, 8'h00, 12'd5));
    send_beat(beat_of(CMD_READ, 8'h00, 12'd6));

    // cursor left far beyond a grid that then shrinks: one scroll only
    set_geometry(8'd32, 8'd128, 1'b0);
    send_beat(beat_of(CMD_WRITE, CH_NEWLINE, 12'd0));
    send_beat(beat_of(CMD_WRITE, CH_NEWLINE, 12'd0));
    set_geometry(8'd1, 8'd1, 1'b0);
    send_beat(beat_of(CMD_WRITE, 8'h71, 12'd0));

    // random phases: extremes of the registers first, then mostly small grids
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin rows = 8'h00; cols = 8'h00; end
        1: begin rows = 8'hFF; cols = 8'hFF; end
        2: begin rows = 8'd1;  cols = 8'd128; end
        3: begin rows = 8'd32; cols = 8'd1; end
        4: begin rows = 8'd27; cols = 8'd80; end
        default: begin
          if ($urandom_range(0, 4) == 0) begin
            rows = $urandom_range(0, 255);
            cols = $urandom_range(0, 255);
          end else begin
            rows = $urandom_range(1, 4);
            cols = $urandom_range(1, 12);
          end
        end
      endcase
      set_geometry(rows, cols, p == 5);
      no_idle = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < BEATS_PER_PHASE; k++) begin
        // long receiver stall while beats keep coming: input must back up
        if (p == 6 && k == 4) begin
          no_idle = 1'b1;
          rx_hold_cycles = 400;
        end
        // sender waits mid-phase for every result to return
        if (p == 7 && k == 32) drain();
        send_beat(random_beat());
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/tccw_pkg.sv
design/tccw_geom.sv
design/text_console_char_writer_unit.sv
bench/tccw_checker.sv
bench/testbench.sv
